>>> rtl/core/lcfd_pkg.sv
package lcfd_pkg;

    // Default length limit of one line; the held count tops out one below it.
    localparam int LINE_BUFFER_BYTES = 64;

    // Only the first eight positions of a line are ever examined.
    localparam int STORED_POSITIONS = 8;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] START_MARK = 8'hAA;
    localparam logic [7:0] STOP_MARK  = 8'h55;
    localparam logic [7:0] NEWLINE    = 8'h0A;

    // Command bytes as they appear at position 1 of a line.
    localparam logic [7:0] CMD_PIXEL = 8'h01;
    localparam logic [7:0] CMD_POWER = 8'h02;
    localparam logic [7:0] CMD_CLEAR = 8'h03;
    localparam logic [7:0] CMD_BOXES = 8'h04;

    // Command kinds as reported on the result channel.
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_RELAY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_BOXES = 2'd3;

    // One accepted command, as handed from the front to the back.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pos2;
        logic [7:0] pos3;
        logic [7:0] pos4;
        logic [7:0] pos5;
        logic [7:0] pos6;
    } cmd_entry_t;

    function automatic logic [15:0] pack565(input logic [7:0] red,
                                            input logic [7:0] green,
                                            input logic [7:0] blue);
        pack565 = {red[7:3], green[7:2], blue[7:3]};
    endfunction

endpackage

>>> rtl/core/lcfd_if.sv
interface lcfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface lcfd_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command_kind;
    logic [7:0]  box_row;
    logic [7:0]  box_col;
    logic [15:0] color_rgb565;
    logic        display_on;

    modport source (output valid, output command_kind, output box_row, output box_col,
                    output color_rgb565, output display_on, input ready);
    modport sink (input valid, input command_kind, input box_row, input box_col,
                  input color_rgb565, input display_on, output ready);
endinterface

>>> rtl/core/led_command_frame_decoder_unit.sv
// LED command line decoder. Received serial bytes arrive one per transfer on the
// rx channel, and one byte can be taken in every clock cycle while the command
// queue is not full. Bytes other than newline (0x0A) build up a line: the first
// eight positions are kept and the line length counts up to LineBufferBytes-1
// and then holds, with further bytes dropped. A newline ends the line. If the
// line starts with 0xAA, position 1 selects pixel colour (0x01), relay (0x02),
// clear (0x03) or light all boxes (0x04); the first three need a long enough
// line and the stop byte 0x55 at their last position. Each valid command gives
// one transfer on the cmd channel with the pixel row, column and RGB565 colour
// or the relay state, and zero in the fields that do not apply. Any newline
// clears the line store, whether or not it produced a command. A newline's
// command is written into the queue as the newline is taken, and moves on into
// the cmd output register once it is at the head of the queue and the output
// register is free or being taken. A two-entry command queue separates line
// capture from result formatting, so the rx side keeps taking bytes while a
// result waits for the sink. The rx channel stalls only when that queue is full,
// which takes two unclaimed commands behind the output register.
module led_command_frame_decoder_unit #(
    parameter int LineBufferBytes = lcfd_pkg::LINE_BUFFER_BYTES,
    parameter int QueueDepth      = lcfd_pkg::QUEUE_DEPTH
) (
    input logic         clk,
    input logic         rst_n,
    lcfd_rx_if.sink     rx,
    lcfd_cmd_if.source  cmd
);

    logic                 push;
    logic                 queue_full;
    logic                 q_valid;
    logic                 q_pop;
    lcfd_pkg::cmd_entry_t push_entry;
    lcfd_pkg::cmd_entry_t q_head;

    // Line capture and command classification.
    lcfd_front #(
        .LineBufferBytes(LineBufferBytes)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Short queue of accepted commands.
    lcfd_queue #(
        .Depth(QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (q_pop),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    // Result formatting and the output register.
    lcfd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .cmd     (cmd)
    );

endmodule

>>> rtl/core/lcfd_front.sv
module lcfd_front #(
    parameter int LineBufferBytes = lcfd_pkg::LINE_BUFFER_BYTES
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lcfd_rx_if.sink              rx,
    input  logic                 queue_full,
    output logic                 push,
    output lcfd_pkg::cmd_entry_t push_entry
);

    localparam int LenW = $clog2(LineBufferBytes);
    localparam logic [LenW-1:0] LenMax = LenW'(LineBufferBytes - 1);

    logic [7:0]      frame_bytes_reg [lcfd_pkg::STORED_POSITIONS];
    logic [7:0]      frame_bytes_next [lcfd_pkg::STORED_POSITIONS];
    logic [LenW-1:0] line_length_reg;
    logic [LenW-1:0] line_length_next;
    logic            take;
    logic            is_newline;
    logic            hit;
    logic [1:0]      kind;

    assign rx.ready   = !queue_full;
    assign take       = rx.valid && rx.ready;
    assign is_newline = (rx.rx_byte == lcfd_pkg::NEWLINE);

    // Classify the finished line. Positions not written on this line hold zero.
    always_comb
    begin
        hit  = 1'b0;
        kind = lcfd_pkg::KIND_BOXES;
        if (line_length_reg != '0 && frame_bytes_reg[0] == lcfd_pkg::START_MARK)
        begin
            priority if (frame_bytes_reg[1] == lcfd_pkg::CMD_PIXEL &&
                         line_length_reg >= LenW'(8))
            begin
                hit  = (frame_bytes_reg[7] == lcfd_pkg::STOP_MARK);
                kind = lcfd_pkg::KIND_PIXEL;
            end
            else if (frame_bytes_reg[1] == lcfd_pkg::CMD_POWER &&
                     line_length_reg >= LenW'(4))
            begin
                hit  = (frame_bytes_reg[3] == lcfd_pkg::STOP_MARK);
                kind = lcfd_pkg::KIND_RELAY;
            end
            else if (frame_bytes_reg[1] == lcfd_pkg::CMD_CLEAR &&
                     line_length_reg >= LenW'(3))
            begin
                hit  = (frame_bytes_reg[2] == lcfd_pkg::STOP_MARK);
                kind = lcfd_pkg::KIND_CLEAR;
            end
            else if (frame_bytes_reg[1] == lcfd_pkg::CMD_BOXES)
            begin
                hit  = 1'b1;
                kind = lcfd_pkg::KIND_BOXES;
            end
            else
            begin
                hit = 1'b0;
            end
        end
    end

    assign push = take && is_newline && hit;

    always_comb
    begin
        push_entry.kind = kind;
        push_entry.pos2 = frame_bytes_reg[2];
        push_entry.pos3 = frame_bytes_reg[3];
        push_entry.pos4 = frame_bytes_reg[4];
        push_entry.pos5 = frame_bytes_reg[5];
        push_entry.pos6 = frame_bytes_reg[6];
    end

    always_comb
    begin
        frame_bytes_next = frame_bytes_reg;
        line_length_next = line_length_reg;
        if (take)
        begin
            if (is_newline)
            begin
                for (int i = 0; i < lcfd_pkg::STORED_POSITIONS; i++)
                begin
                    frame_bytes_next[i] = '0;
                end
                line_length_next = '0;
            end
            else if (line_length_reg < LenMax)
            begin
                if (line_length_reg < LenW'(lcfd_pkg::STORED_POSITIONS))
                begin
                    frame_bytes_next[line_length_reg[2:0]] = rx.rx_byte;
                end
                line_length_next = line_length_reg + LenW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lcfd_pkg::STORED_POSITIONS; i++)
            begin
                frame_bytes_reg[i] <= '0;
            end
            line_length_reg <= '0;
        end
        else
        begin
            frame_bytes_reg <= frame_bytes_next;
            line_length_reg <= line_length_next;
        end
    end

endmodule

>>> rtl/core/lcfd_queue.sv
module lcfd_queue #(
    parameter int Depth = lcfd_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lcfd_pkg::cmd_entry_t push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output lcfd_pkg::cmd_entry_t head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    lcfd_pkg::cmd_entry_t entries [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == CntW'(Depth));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/lcfd_back.sv
module lcfd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  lcfd_pkg::cmd_entry_t q_head,
    output logic                 q_pop,
    lcfd_cmd_if.source           cmd
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  kind_reg;
    logic [7:0]  row_reg;
    logic [7:0]  col_reg;
    logic [15:0] color_reg;
    logic        disp_reg;
    logic [7:0]  row_next;
    logic [7:0]  col_next;
    logic [15:0] color_next;
    logic        disp_next;

    assign q_pop = q_valid && (!out_valid_reg || cmd.ready);

    always_comb
    begin
        row_next   = '0;
        col_next   = '0;
        color_next = '0;
        disp_next  = 1'b0;
        unique case (q_head.kind)
            lcfd_pkg::KIND_PIXEL:
            begin
                row_next   = q_head.pos2;
                col_next   = q_head.pos3;
                color_next = lcfd_pkg::pack565(q_head.pos4, q_head.pos5, q_head.pos6);
            end
            lcfd_pkg::KIND_RELAY:
            begin
                disp_next = (q_head.pos2 != '0);
            end
            default:
            begin
                disp_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (cmd.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg  <= q_head.kind;
            row_reg   <= row_next;
            col_reg   <= col_next;
            color_reg <= color_next;
            disp_reg  <= disp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmd.valid        = out_valid_reg;
    assign cmd.command_kind = kind_reg;
    assign cmd.box_row      = row_reg;
    assign cmd.box_col      = col_reg;
    assign cmd.color_rgb565 = color_reg;
    assign cmd.display_on   = disp_reg;

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    // One command as it leaves the block on the cmd channel.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [15:0] color;
        logic        lit;
    } led_cmd_t;

    // One row of the directed table: up to twelve bytes, right aligned, the first
    // byte of the line in the highest byte that is in use. Where the outcome can be
    // read straight off the line, it is written into the row; every other row is
    // left to the line decoder model below.
    typedef struct packed {
        int unsigned count;
        logic [95:0] bytes;
        logic        fixed;
        logic        fires;
        led_cmd_t    cmd;
    } line_row_t;

    // Ways in which the command sink takes transfers when it is not held off.
    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } sink_mode_e;

    logic clk = 1'b0;
    logic rst_n;

    lcfd_rx_if  rx ();
    lcfd_cmd_if cmd ();

    led_command_frame_decoder_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .cmd   (cmd)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Model of the line decoder: the stored head of the current line and its held
    // length. Both return to zero after every newline.
    logic [7:0]  line_bytes [lcfd_pkg::STORED_POSITIONS];
    int unsigned line_len = 0;

    // Commands that the model has predicted and the sink has not yet seen.
    led_cmd_t    pending_cmds [$];

    line_row_t   directed_lines [$];
    logic [7:0]  random_line [$];

    int          mismatches = 0;
    int          bytes_sent = 0;
    int          burst_left = 0;

    // Sink side controls. The sender asks for a long hold-off through
    // hold_request; the sink counts the hold-off down on its own.
    bit          hold_request = 0;
    bit          hold_done = 0;
    int          hold_left = 0;
    bit          draining = 0;
    sink_mode_e  sink_mode = SINK_OPEN;
    int          mode_left = 0;
    int unsigned sink_cycle = 0;

    // Feeds one byte into the line model. A byte other than newline is appended,
    // with only the first eight positions stored and the length held one below the
    // buffer size. A newline decodes the line and clears it.
    function automatic void decode_rx_byte(input logic [7:0] b, output bit fires,
                                           output led_cmd_t res);
        logic [7:0] op;
        fires = 1'b0;
        res   = '0;
        if (b != lcfd_pkg::NEWLINE)
        begin
            if (line_len < lcfd_pkg::LINE_BUFFER_BYTES - 1)
            begin
                if (line_len < lcfd_pkg::STORED_POSITIONS)
                    line_bytes[3'(line_len)] = b;
                line_len++;
            end
            return;
        end
        op = line_bytes[1];
        if (line_len > 0 && line_bytes[0] == lcfd_pkg::START_MARK)
        begin
            // Note the chain: a pixel line that is too short is not retried as
            // another command, it simply gives nothing.
            if (op == lcfd_pkg::CMD_PIXEL && line_len >= 8)
            begin
                if (line_bytes[7] == lcfd_pkg::STOP_MARK)
                begin
                    fires     = 1'b1;
                    res.kind  = lcfd_pkg::KIND_PIXEL;
                    res.row   = line_bytes[2];
                    res.col   = line_bytes[3];
                    res.color = ((16'(line_bytes[4]) & 16'h00F8) << 8) |
                                ((16'(line_bytes[5]) & 16'h00FC) << 3) |
                                (16'(line_bytes[6]) >> 3);
                end
            end
            else if (op == lcfd_pkg::CMD_POWER && line_len >= 4)
            begin
                if (line_bytes[3] == lcfd_pkg::STOP_MARK)
                begin
                    fires    = 1'b1;
                    res.kind = lcfd_pkg::KIND_RELAY;
                    res.lit  = (line_bytes[2] != 8'h00);
                end
            end
            else if (op == lcfd_pkg::CMD_CLEAR && line_len >= 3)
            begin
                if (line_bytes[2] == lcfd_pkg::STOP_MARK)
                begin
                    fires    = 1'b1;
                    res.kind = lcfd_pkg::KIND_CLEAR;
                end
            end
            else if (op == lcfd_pkg::CMD_BOXES)
            begin
                fires    = 1'b1;
                res.kind = lcfd_pkg::KIND_BOXES;
            end
        end
        foreach (line_bytes[i])
            line_bytes[i] = 8'h00;
        line_len = 0;
    endfunction

    function automatic line_row_t line_row(input int unsigned n, input logic [95:0] b,
                                           input logic fixed, input logic fires,
                                           input logic [1:0] kind, input logic [7:0] row,
                                           input logic [7:0] col, input logic [15:0] color,
                                           input logic lit);
        line_row_t r;
        r.count     = n;
        r.bytes     = b;
        r.fixed     = fixed;
        r.fires     = fires;
        r.cmd.kind  = kind;
        r.cmd.row   = row;
        r.cmd.col   = col;
        r.cmd.color = color;
        r.cmd.lit   = lit;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Compares one command transfer with the oldest prediction, field by field.
    task automatic check_command();
        led_cmd_t want;
        if (pending_cmds.size() == 0)
        begin
            report_mismatch($sformatf("command kind %0d arrived with none expected",
                                      cmd.command_kind));
            return;
        end
        want = pending_cmds.pop_front();
        if (cmd.command_kind !== want.kind)
            report_mismatch($sformatf("command_kind %0d, expected %0d",
                                      cmd.command_kind, want.kind));
        if (cmd.box_row !== want.row)
            report_mismatch($sformatf("box_row %02h, expected %02h", cmd.box_row, want.row));
        if (cmd.box_col !== want.col)
            report_mismatch($sformatf("box_col %02h, expected %02h", cmd.box_col, want.col));
        if (cmd.color_rgb565 !== want.color)
            report_mismatch($sformatf("color_rgb565 %04h, expected %04h",
                                      cmd.color_rgb565, want.color));
        if (cmd.display_on !== want.lit)
            report_mismatch($sformatf("display_on %b, expected %b", cmd.display_on, want.lit));
    endtask

    // Offers one byte on the rx channel and returns at the edge where it was taken.
    // The sender works in bursts: when a burst runs out it drops valid for a few
    // cycles and then starts a new one. Now and then a burst is long, so that there
    // are stretches with no gaps at all. Valid stays high from one byte to the next
    // inside a burst. Once the transfer has happened the byte goes through the model;
    // predict is cleared for directed rows whose outcome is written in the table.
    task automatic transfer_byte(input logic [7:0] b, input bit predict);
        bit       fires;
        led_cmd_t res;
        if (burst_left == 0)
        begin
            rx.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250)
                                                       : $urandom_range(1, 16);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        do
            @(posedge clk);
        while (rx.ready !== 1'b1);
        burst_left--;
        bytes_sent++;
        decode_rx_byte(b, fires, res);
        if (predict && fires)
            pending_cmds.push_back(res);
    endtask

    // Builds the body of one random line, without its newline. Most lines are
    // well-formed commands with random content, since only those reach the command
    // decode. The rest have a broken stop byte, are cut short, are plain noise,
    // carry an unknown command byte, or run up to or past the held length.
    task automatic build_random_line();
        int pick;
        int cut;
        int fill;
        random_line.delete();
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            random_line.push_back(lcfd_pkg::START_MARK);
            case ($urandom_range(0, 3))
                0:
                begin
                    random_line.push_back(lcfd_pkg::CMD_PIXEL);
                    repeat (5) random_line.push_back(8'($urandom_range(0, 255)));
                    random_line.push_back(lcfd_pkg::STOP_MARK);
                end
                1:
                begin
                    random_line.push_back(lcfd_pkg::CMD_POWER);
                    random_line.push_back($urandom_range(0, 1) ? 8'h00
                                                               : 8'($urandom_range(0, 255)));
                    random_line.push_back(lcfd_pkg::STOP_MARK);
                end
                2:
                begin
                    random_line.push_back(lcfd_pkg::CMD_CLEAR);
                    random_line.push_back(lcfd_pkg::STOP_MARK);
                end
                default:
                begin
                    random_line.push_back(lcfd_pkg::CMD_BOXES);
                    repeat ($urandom_range(0, 4))
                        random_line.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            if (pick >= 60 && pick < 70)
            begin
                random_line[random_line.size() - 1] = 8'($urandom_range(0, 255));
            end
            else if (pick >= 70)
            begin
                cut = $urandom_range(0, random_line.size() - 1);
                while (random_line.size() > cut)
                    void'(random_line.pop_back());
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 3)) random_line.push_back(8'($urandom_range(0, 255)));
            end
        end
        else if (pick < 88)
        begin
            fill = $urandom_range(0, 10);
            repeat (fill) random_line.push_back(8'($urandom_range(0, 255)));
            if (fill > 0 && $urandom_range(0, 1))
                random_line[0] = lcfd_pkg::START_MARK;
        end
        else if (pick < 96)
        begin
            random_line.push_back(lcfd_pkg::START_MARK);
            random_line.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 8)) random_line.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            // A valid pixel head followed by filler up to or beyond the held length.
            random_line.push_back(lcfd_pkg::START_MARK);
            random_line.push_back(lcfd_pkg::CMD_PIXEL);
            repeat (5) random_line.push_back(8'($urandom_range(0, 255)));
            random_line.push_back(lcfd_pkg::STOP_MARK);
            fill = $urandom_range(60, 80);
            while (random_line.size() < fill)
            begin
                random_line.push_back(8'($urandom_range(0, 255)));
                if (random_line[random_line.size() - 1] == lcfd_pkg::NEWLINE)
                    random_line[random_line.size() - 1] = 8'h0B;
            end
        end
    endtask

    // Command sink. Each rising edge first checks a transfer that happens at that
    // edge, then sets ready for the next one. Ready follows a mode picked anew at
    // random: always open, a coin toss, mostly closed, or a fixed on/off rhythm.
    // A hold-off asked for by the sender closes the sink for a long stretch so that
    // the command queue fills and the rx side has to stall. At the end the sink
    // stays open to drain what is left.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && cmd.valid === 1'b1 && cmd.ready === 1'b1)
            check_command();
        if (mode_left == 0)
        begin
            sink_mode = sink_mode_e'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
        end
        else
            mode_left--;
        if (hold_request && !hold_done)
        begin
            hold_left = 400;
            hold_done = 1;
        end
        sink_cycle++;
        if (rst_n !== 1'b1)
            cmd.ready <= 1'b0;
        else if (draining)
            cmd.ready <= 1'b1;
        else if (hold_left != 0)
        begin
            hold_left--;
            cmd.ready <= 1'b0;
        end
        else
        begin
            case (sink_mode)
                SINK_OPEN:   cmd.ready <= 1'b1;
                SINK_COIN:   cmd.ready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: cmd.ready <= ($urandom_range(0, 3) == 0);
                default:     cmd.ready <= ((sink_cycle % 7) < 4);
            endcase
        end
    end

    // Stimulus: reset, the directed table, then random lines until about 1750 bytes
    // have been taken. The directed rows cover the empty line, a line too short to
    // carry a command byte, each command at the extremes of its fields, an unknown
    // command byte, a wrong stop byte, a line too short for its command and a
    // newline inside a pixel payload. Lines past the held length come in the random
    // part. Partway through, the sink is held off for a long stretch while bytes keep
    // coming, and later the sender stops until every predicted command has arrived.
    initial
    begin
        line_row_t   r;
        int          line_no;
        int unsigned n;

        rx.valid   <= 1'b0;
        rx.rx_byte <= 8'h00;
        rst_n      <= 1'b0;
        foreach (line_bytes[i])
            line_bytes[i] = 8'h00;

        directed_lines.push_back(line_row(1, 96'h0A, 1'b1, 1'b0, lcfd_pkg::KIND_PIXEL,
                                          8'h00, 8'h00, 16'h0000, 1'b0));
        directed_lines.push_back(line_row(3, 96'hAA040A, 1'b1, 1'b1, lcfd_pkg::KIND_BOXES,
                                          8'h00, 8'h00, 16'h0000, 1'b0));
        directed_lines.push_back(line_row(2, 96'hAA0A, 1'b1, 1'b0, lcfd_pkg::KIND_PIXEL,
                                          8'h00, 8'h00, 16'h0000, 1'b0));
        directed_lines.push_back(line_row(4, 96'hAA03550A, 1'b1, 1'b1, lcfd_pkg::KIND_CLEAR,
                                          8'h00, 8'h00, 16'h0000, 1'b0));
        directed_lines.push_back(line_row(5, 96'hAA0200550A, 1'b1, 1'b1, lcfd_pkg::KIND_RELAY,
                                          8'h00, 8'h00, 16'h0000, 1'b0));
        directed_lines.push_back(line_row(9, 96'hAA01FF00FFFFFF550A, 1'b1, 1'b1,
                                          lcfd_pkg::KIND_PIXEL, 8'hFF, 8'h00, 16'hFFFF,
                                          1'b0));
        directed_lines.push_back(line_row(3, 96'hAAFF0A, 1'b1, 1'b0, lcfd_pkg::KIND_PIXEL,
                                          8'h00, 8'h00, 16'h0000, 1'b0));
        directed_lines.push_back(line_row(4, 96'hAA03540A, 1'b1, 1'b0, lcfd_pkg::KIND_PIXEL,
                                          8'h00, 8'h00, 16'h0000, 1'b0));
        directed_lines.push_back(line_row(5, 96'hAA010A050A, 1'b0, 1'b0, lcfd_pkg::KIND_PIXEL,
                                          8'h00, 8'h00, 16'h0000, 1'b0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_lines[k])
        begin
            r = directed_lines[k];
            n = r.count;
            for (int i = 0; i < n; i++)
                transfer_byte(r.bytes[8 * (n - 1 - i) +: 8], !r.fixed);
            if (r.fixed && r.fires)
                pending_cmds.push_back(r.cmd);
        end

        line_no = 0;
        while (bytes_sent < 1750)
        begin
            build_random_line();
            foreach (random_line[i])
                transfer_byte(random_line[i], 1);
            transfer_byte(lcfd_pkg::NEWLINE, 1);
            line_no++;
            if (line_no == 60)
                hold_request = 1;
            if (line_no == 120)
            begin
                rx.valid <= 1'b0;
                @(posedge clk);
                while (pending_cmds.size() != 0)
                    @(posedge clk);
            end
        end

        rx.valid <= 1'b0;
        draining = 1;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        // A few more cycles to catch a stray command behind the last one.
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far longer than the slowest correct run needs.
    initial
    begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
